/* rtl/core/gtcl_pkg.sv */
// Shared types, constants and a helper function of the glyph text cursor layout block.
package gtcl_pkg;

    localparam int CODE_COUNT_DEF = 128;

    localparam logic [11:0] CURSOR_MAX = 12'd4095;
    localparam logic [14:0] ATLAS_MAX  = 15'd32767;

    localparam logic [6:0] CHAR_CLEAR   = 7'd0;
    localparam logic [6:0] CHAR_NEWLINE = 7'd10;
    localparam logic [6:0] CHAR_SPACE   = 7'd32;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PLACE = 1'b1;

    localparam int          APB_AW = 5;
    localparam logic [2:0] REG_TARGET_WIDTH  = 3'd0;
    localparam logic [2:0] REG_TARGET_HEIGHT = 3'd1;
    localparam logic [2:0] REG_GLYPH_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_SPACING_X     = 3'd3;
    localparam logic [2:0] REG_SPACING_Y     = 3'd4;

    localparam logic [11:0] TARGET_WIDTH_RST  = 12'd640;
    localparam logic [11:0] TARGET_HEIGHT_RST = 12'd480;
    localparam logic [7:0]  GLYPH_HEIGHT_RST  = 8'd16;
    localparam logic [7:0]  SPACING_X_RST     = 8'd0;
    localparam logic [7:0]  SPACING_Y_RST     = 8'd0;

    typedef struct packed {
        logic [11:0] target_width;
        logic [11:0] target_height;
        logic [7:0]  glyph_height;
        logic [7:0]  spacing_x;
        logic [7:0]  spacing_y;
    } cfg_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EXEC  = 7'b0000010,
        ST_FETCH = 7'b0000100,
        ST_WALK  = 7'b0001000,
        ST_WRAP  = 7'b0010000,
        ST_PLACE = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic capture;
        logic do_load;
        logic do_space;
        logic do_newline;
        logic do_clear;
        logic read_code;
        logic take_glyph;
        logic walk_step;
        logic do_wrap;
        logic do_place;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic is_load;
        logic is_space;
        logic is_newline;
        logic is_clear;
        logic is_glyph;
        logic width_zero;
        logic walk_last;
        logic out_free;
    } sts_t;

    function automatic logic [11:0] sat_cursor(input logic [13:0] v);
        sat_cursor = (v > {2'b00, CURSOR_MAX}) ? CURSOR_MAX : v[11:0];
    endfunction

endpackage

/* rtl/core/gtcl_if.sv */
// Valid/ready channel interfaces for the input items and the result items.
interface gtcl_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [6:0] char_code;
    logic [7:0] load_width;
    logic [7:0] load_advance;

    modport source (output valid, action, char_code, load_width, load_advance, input ready);
    modport sink (input valid, action, char_code, load_width, load_advance, output ready);
endinterface

interface gtcl_out_if;
    logic        valid;
    logic        ready;
    logic        draw;
    logic        cleared;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [14:0] atlas_x;
    logic [7:0]  width_out;

    modport source (output valid, draw, cleared, dest_x, dest_y, atlas_x, width_out,
                    input ready);
    modport sink (input valid, draw, cleared, dest_x, dest_y, atlas_x, width_out,
                  output ready);
endinterface

/* rtl/core/glyph_text_cursor_layout.sv */
// Top level of the glyph text cursor layout block.
//
// Input channel in_ch carries one item per transfer: action 0 loads the width and
// advance of one character code into the glyph table (a second load to the same code
// is dropped), action 1 places a character and moves the text cursor.
// Output channel out_ch returns exactly one result per input item, in order.
// The APB port holds target_width, target_height, glyph_height, spacing_x and
// spacing_y at byte addresses 0, 4, 8, 12 and 16; write them only while idle.
//
// One item is worked on at a time. Loads, spaces, newlines, clears and unloaded
// codes go from the execute state to the done state, and a loaded glyph of width
// zero passes the fetch state between them. A drawn glyph of code c also passes the
// walk, wrap and place states: the atlas x position walks the c lower table entries
// through the single read port of the glyph table memory, one entry per cycle. The
// result becomes valid when the done state writes it into the output register.
// The result sits in an output register, so the next item is accepted while it waits;
// a stalled receiver holds the block only once a further result is ready to go.
// Reset clears the cursor, all glyph table valid bits and the output valid bit, and
// loads the configuration defaults; no clearing pass is needed.
module glyph_text_cursor_layout #(
    parameter int CODE_COUNT = gtcl_pkg::CODE_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    gtcl_in_if.sink                     in_ch,
    gtcl_out_if.source                  out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gtcl_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    gtcl_pkg::cfg_t cfg;
    gtcl_pkg::cmd_t cmd;
    gtcl_pkg::sts_t sts;

    gtcl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gtcl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gtcl_dp #(
        .CODE_COUNT (CODE_COUNT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .sts             (sts),
        .in_action       (in_ch.action),
        .in_char_code    (in_ch.char_code),
        .in_load_width   (in_ch.load_width),
        .in_load_advance (in_ch.load_advance),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .out_draw        (out_ch.draw),
        .out_cleared     (out_ch.cleared),
        .out_dest_x      (out_ch.dest_x),
        .out_dest_y      (out_ch.dest_y),
        .out_atlas_x     (out_ch.atlas_x),
        .out_width_out   (out_ch.width_out)
    );

endmodule

/* rtl/core/gtcl_cfg.sv */
// APB configuration register file of the glyph text cursor layout block.
module gtcl_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gtcl_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output gtcl_pkg::cfg_t             cfg
);

    gtcl_pkg::cfg_t cfg_reg;
    gtcl_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                gtcl_pkg::REG_TARGET_WIDTH:  cfg_next.target_width  = pwdata[11:0];
                gtcl_pkg::REG_TARGET_HEIGHT: cfg_next.target_height = pwdata[11:0];
                gtcl_pkg::REG_GLYPH_HEIGHT:  cfg_next.glyph_height  = pwdata[7:0];
                gtcl_pkg::REG_SPACING_X:     cfg_next.spacing_x     = pwdata[7:0];
                gtcl_pkg::REG_SPACING_Y:     cfg_next.spacing_y     = pwdata[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            gtcl_pkg::REG_TARGET_WIDTH:  prdata = {20'd0, cfg_reg.target_width};
            gtcl_pkg::REG_TARGET_HEIGHT: prdata = {20'd0, cfg_reg.target_height};
            gtcl_pkg::REG_GLYPH_HEIGHT:  prdata = {24'd0, cfg_reg.glyph_height};
            gtcl_pkg::REG_SPACING_X:     prdata = {24'd0, cfg_reg.spacing_x};
            gtcl_pkg::REG_SPACING_Y:     prdata = {24'd0, cfg_reg.spacing_y};
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_width  <= gtcl_pkg::TARGET_WIDTH_RST;
            cfg_reg.target_height <= gtcl_pkg::TARGET_HEIGHT_RST;
            cfg_reg.glyph_height  <= gtcl_pkg::GLYPH_HEIGHT_RST;
            cfg_reg.spacing_x     <= gtcl_pkg::SPACING_X_RST;
            cfg_reg.spacing_y     <= gtcl_pkg::SPACING_Y_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/gtcl_ctrl.sv */
// Sequencing state machine of the glyph text cursor layout block.
module gtcl_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  gtcl_pkg::sts_t  sts,
    output gtcl_pkg::cmd_t  cmd
);

    gtcl_pkg::state_t state_reg;
    gtcl_pkg::state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            gtcl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = gtcl_pkg::ST_EXEC;
                end
            end
            gtcl_pkg::ST_EXEC:
            begin
                state_next = gtcl_pkg::ST_DONE;
                if (sts.is_load)
                begin
                    cmd.do_load = 1'b1;
                end
                else if (sts.is_space)
                begin
                    cmd.do_space = 1'b1;
                end
                else if (sts.is_newline)
                begin
                    cmd.do_newline = 1'b1;
                end
                else if (sts.is_clear)
                begin
                    cmd.do_clear = 1'b1;
                end
                else if (sts.is_glyph)
                begin
                    cmd.read_code = 1'b1;
                    state_next    = gtcl_pkg::ST_FETCH;
                end
            end
            gtcl_pkg::ST_FETCH:
            begin
                // A glyph of width zero is handled like an unloaded one.
                if (sts.width_zero)
                begin
                    state_next = gtcl_pkg::ST_DONE;
                end
                else
                begin
                    cmd.take_glyph = 1'b1;
                    state_next     = gtcl_pkg::ST_WALK;
                end
            end
            gtcl_pkg::ST_WALK:
            begin
                if (sts.walk_last)
                begin
                    state_next = gtcl_pkg::ST_WRAP;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            gtcl_pkg::ST_WRAP:
            begin
                cmd.do_wrap = 1'b1;
                state_next  = gtcl_pkg::ST_PLACE;
            end
            gtcl_pkg::ST_PLACE:
            begin
                cmd.do_place = 1'b1;
                state_next   = gtcl_pkg::ST_DONE;
            end
            gtcl_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = gtcl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gtcl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gtcl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == gtcl_pkg::ST_IDLE);

endmodule

/* rtl/core/gtcl_dp.sv */
// Datapath: glyph table memory, cursor, atlas accumulator and result register.
module gtcl_dp #(
    parameter int CODE_COUNT = gtcl_pkg::CODE_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  gtcl_pkg::cfg_t  cfg,
    input  gtcl_pkg::cmd_t  cmd,
    output gtcl_pkg::sts_t  sts,
    input  logic            in_action,
    input  logic [6:0]      in_char_code,
    input  logic [7:0]      in_load_width,
    input  logic [7:0]      in_load_advance,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            out_draw,
    output logic            out_cleared,
    output logic [11:0]     out_dest_x,
    output logic [11:0]     out_dest_y,
    output logic [14:0]     out_atlas_x,
    output logic [7:0]      out_width_out
);

    localparam int AW = (CODE_COUNT > 1) ? $clog2(CODE_COUNT) : 1;

    // Item registers.
    logic        act_reg;
    logic [6:0]  code_reg;
    logic [7:0]  lw_reg;
    logic [7:0]  la_reg;

    // Glyph table.
    logic [15:0]           mem [CODE_COUNT];
    logic [CODE_COUNT-1:0] valid_reg;
    logic [CODE_COUNT-1:0] valid_next;
    logic [15:0]           rd_data_reg;
    logic                  rd_valid_reg;
    logic                  rd_walk_reg;

    // Cursor and per-glyph work registers.
    logic [11:0] cursor_x_reg;
    logic [11:0] cursor_x_next;
    logic [11:0] cursor_y_reg;
    logic [11:0] cursor_y_next;
    logic [7:0]  gw_reg;
    logic [7:0]  gadv_reg;
    logic [6:0]  idx_reg;
    logic [14:0] sum_reg;

    // Pending result, then the output register.
    logic        res_draw_reg;
    logic        res_cleared_reg;
    logic [11:0] res_x_reg;
    logic [11:0] res_y_reg;
    logic [14:0] res_atlas_reg;
    logic [7:0]  res_w_reg;
    logic        out_valid_reg;
    logic        out_draw_reg;
    logic        out_cleared_reg;
    logic [11:0] out_x_reg;
    logic [11:0] out_y_reg;
    logic [14:0] out_atlas_reg;
    logic [7:0]  out_w_reg;

    logic [8:0]    code_ext;
    logic [8:0]    idx_ext;
    logic [AW-1:0] code_addr;
    logic [AW-1:0] idx_addr;
    logic [AW-1:0] rd_addr;
    logic          code_in_range;
    logic          code_loaded;
    logic          wr_en;
    logic          rd_en;
    logic [13:0]   space_x;
    logic [13:0]   newline_y;
    logic [13:0]   advance_x;
    logic [12:0]   wrap_right;
    logic [12:0]   wrap_bottom;
    logic          need_wrap;
    logic          need_clear;
    logic [15:0]   sum_wide;
    logic [14:0]   sum_sat;

    assign code_ext      = {2'b00, code_reg};
    assign idx_ext       = {2'b00, idx_reg};
    assign code_addr     = code_ext[AW-1:0];
    assign idx_addr      = idx_ext[AW-1:0];
    assign code_in_range = (code_ext < 9'(CODE_COUNT));
    assign code_loaded   = code_in_range && valid_reg[code_addr];

    assign sts.is_load    = (act_reg == gtcl_pkg::ACT_LOAD);
    assign sts.is_space   = (act_reg == gtcl_pkg::ACT_PLACE) && (code_reg == gtcl_pkg::CHAR_SPACE);
    assign sts.is_newline = (act_reg == gtcl_pkg::ACT_PLACE)
                            && (code_reg == gtcl_pkg::CHAR_NEWLINE);
    assign sts.is_clear   = (act_reg == gtcl_pkg::ACT_PLACE) && (code_reg == gtcl_pkg::CHAR_CLEAR);
    assign sts.is_glyph   = (act_reg == gtcl_pkg::ACT_PLACE) && code_loaded;
    assign sts.width_zero = (rd_data_reg[15:8] == 8'd0);
    assign sts.walk_last  = (idx_reg == code_reg);
    assign sts.out_free   = !out_valid_reg || out_ready;

    // A repeated load to an already loaded code leaves the entry alone.
    assign wr_en   = cmd.do_load && code_in_range && !valid_reg[code_addr];
    assign rd_en   = cmd.read_code || cmd.walk_step;
    assign rd_addr = cmd.walk_step ? idx_addr : code_addr;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[code_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[code_addr] <= {lw_reg, la_reg};
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign space_x     = {2'b00, cursor_x_reg} + {7'd0, cfg.glyph_height[7:1]}
                         + {6'd0, cfg.spacing_x};
    assign newline_y   = {2'b00, cursor_y_reg} + {6'd0, cfg.glyph_height}
                         + {6'd0, cfg.spacing_y};
    assign advance_x   = {2'b00, cursor_x_reg} + {6'd0, gadv_reg} + {6'd0, cfg.spacing_x};
    assign wrap_right  = {1'b0, cursor_x_reg} + {5'd0, gw_reg};
    assign wrap_bottom = {1'b0, cursor_y_reg} + {5'd0, cfg.glyph_height};
    assign need_wrap   = wrap_right > {1'b0, cfg.target_width};
    assign need_clear  = wrap_bottom > {1'b0, cfg.target_height};

    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (cmd.do_space)
        begin
            cursor_x_next = gtcl_pkg::sat_cursor(space_x);
        end
        else if (cmd.do_newline)
        begin
            cursor_x_next = 12'd0;
            cursor_y_next = gtcl_pkg::sat_cursor(newline_y);
        end
        else if (cmd.do_clear)
        begin
            cursor_x_next = 12'd0;
            cursor_y_next = 12'd0;
        end
        else if (cmd.do_wrap && need_wrap)
        begin
            cursor_x_next = 12'd0;
            cursor_y_next = need_clear ? 12'd0 : gtcl_pkg::sat_cursor(newline_y);
        end
        else if (cmd.do_place)
        begin
            cursor_x_next = gtcl_pkg::sat_cursor(advance_x);
        end
    end

    assign sum_wide = {1'b0, sum_reg} + {8'd0, rd_data_reg[15:8]};
    assign sum_sat  = (sum_wide > {1'b0, gtcl_pkg::ATLAS_MAX}) ? gtcl_pkg::ATLAS_MAX
                                                              : sum_wide[14:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            cursor_x_reg  <= 12'd0;
            cursor_y_reg  <= 12'd0;
            rd_walk_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            rd_walk_reg  <= cmd.walk_step;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg         <= in_action;
            code_reg        <= in_char_code;
            lw_reg          <= in_load_width;
            la_reg          <= in_load_advance;
            res_draw_reg    <= 1'b0;
            res_cleared_reg <= 1'b0;
            res_x_reg       <= 12'd0;
            res_y_reg       <= 12'd0;
            res_atlas_reg   <= 15'd0;
            res_w_reg       <= 8'd0;
        end
        if (cmd.do_clear || (cmd.do_wrap && need_wrap && need_clear))
        begin
            res_cleared_reg <= 1'b1;
        end
        if (cmd.take_glyph)
        begin
            gw_reg   <= rd_data_reg[15:8];
            gadv_reg <= rd_data_reg[7:0];
            idx_reg  <= 7'd0;
            sum_reg  <= 15'd0;
        end
        else
        begin
            if (cmd.walk_step)
            begin
                idx_reg <= idx_reg + 7'd1;
            end
            // Each table read of the walk lands in the cycle after its address.
            if (rd_walk_reg && rd_valid_reg)
            begin
                sum_reg <= sum_sat;
            end
        end
        if (cmd.do_place)
        begin
            res_draw_reg  <= 1'b1;
            res_x_reg     <= cursor_x_reg;
            res_y_reg     <= cursor_y_reg;
            res_atlas_reg <= sum_reg;
            res_w_reg     <= gw_reg;
        end
        if (cmd.emit)
        begin
            out_draw_reg    <= res_draw_reg;
            out_cleared_reg <= res_cleared_reg;
            out_x_reg       <= res_x_reg;
            out_y_reg       <= res_y_reg;
            out_atlas_reg   <= res_atlas_reg;
            out_w_reg       <= res_w_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_draw      = out_draw_reg;
    assign out_cleared   = out_cleared_reg;
    assign out_dest_x    = out_x_reg;
    assign out_dest_y    = out_y_reg;
    assign out_atlas_x   = out_atlas_reg;
    assign out_width_out = out_w_reg;

`ifndef SYNTHESIS
    a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result written over an untaken transfer");

    a_walk_below_code: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> (idx_reg < code_reg))
        else $error("atlas walk read past the glyph code");

    a_valid_never_drops: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (($past(valid_reg) & ~valid_reg) == '0))
        else $error("a loaded table entry lost its valid bit");

    a_draw_has_width: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_draw_reg) |-> (out_w_reg != 8'd0))
        else $error("placed glyph reported with zero width");
`endif

endmodule

/* bench/glyph_text_cursor_layout_tb.sv */
// Self-checking testbench for the glyph text cursor layout block.
module glyph_text_cursor_layout_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CODES       = 128;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 265;
    localparam int DRAIN_WAIT  = 150;

    typedef struct packed {
        logic       action;
        logic [6:0] char_code;
        logic [7:0] load_width;
        logic [7:0] load_advance;
    } glyph_item_t;

    typedef struct packed {
        logic        draw;
        logic        cleared;
        logic [11:0] dest_x;
        logic [11:0] dest_y;
        logic [14:0] atlas_x;
        logic [7:0]  width_out;
    } layout_result_t;

    // Predicts the cursor walk and keeps the layout results still owed by the block.
    class layout_scoreboard;
        int tgt_w;
        int tgt_h;
        int glyph_h;
        int gap_x;
        int gap_y;
        int cur_x;
        int cur_y;
        bit loaded[CODES];
        int glyph_w[CODES];
        int glyph_adv[CODES];
        layout_result_t owed_q[$];
        int errors;

        function new();
            tgt_w   = int'(gtcl_pkg::TARGET_WIDTH_RST);
            tgt_h   = int'(gtcl_pkg::TARGET_HEIGHT_RST);
            glyph_h = int'(gtcl_pkg::GLYPH_HEIGHT_RST);
            gap_x   = int'(gtcl_pkg::SPACING_X_RST);
            gap_y   = int'(gtcl_pkg::SPACING_Y_RST);
            cur_x   = 0;
            cur_y   = 0;
            errors  = 0;
            foreach (loaded[i]) loaded[i] = 1'b0;
        endfunction

        function int clamp_cursor(int v);
            return (v > int'(gtcl_pkg::CURSOR_MAX)) ? int'(gtcl_pkg::CURSOR_MAX) : v;
        endfunction

        function void line_break();
            cur_x = 0;
            cur_y = clamp_cursor(cur_y + glyph_h + gap_y);
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                gtcl_pkg::REG_TARGET_WIDTH:  tgt_w   = int'(val[11:0]);
                gtcl_pkg::REG_TARGET_HEIGHT: tgt_h   = int'(val[11:0]);
                gtcl_pkg::REG_GLYPH_HEIGHT:  glyph_h = int'(val[7:0]);
                gtcl_pkg::REG_SPACING_X:     gap_x   = int'(val[7:0]);
                gtcl_pkg::REG_SPACING_Y:     gap_y   = int'(val[7:0]);
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [2:0] idx);
            case (idx)
                gtcl_pkg::REG_TARGET_WIDTH:  return 32'(tgt_w);
                gtcl_pkg::REG_TARGET_HEIGHT: return 32'(tgt_h);
                gtcl_pkg::REG_GLYPH_HEIGHT:  return 32'(glyph_h);
                gtcl_pkg::REG_SPACING_X:     return 32'(gap_x);
                gtcl_pkg::REG_SPACING_Y:     return 32'(gap_y);
                default:                     return 32'd0;
            endcase
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void note_item(glyph_item_t it);
            layout_result_t r;
            int code;
            int w;
            int sum;
            r    = '0;
            code = int'(it.char_code);
            if (it.action == gtcl_pkg::ACT_LOAD)
            begin
                // Only the first load of a code sticks.
                if (!loaded[code])
                begin
                    loaded[code]    = 1'b1;
                    glyph_w[code]   = int'(it.load_width);
                    glyph_adv[code] = int'(it.load_advance);
                end
            end
            else if (it.char_code == gtcl_pkg::CHAR_SPACE)
            begin
                cur_x = clamp_cursor(cur_x + glyph_h / 2 + gap_x);
            end
            else if (it.char_code == gtcl_pkg::CHAR_NEWLINE)
            begin
                line_break();
            end
            else if (it.char_code == gtcl_pkg::CHAR_CLEAR)
            begin
                cur_x = 0;
                cur_y = 0;
                r.cleared = 1'b1;
            end
            else if (loaded[code] && glyph_w[code] != 0)
            begin
                w = glyph_w[code];
                if (cur_x + w > tgt_w)
                begin
                    if (cur_y + glyph_h > tgt_h)
                    begin
                        cur_x = 0;
                        cur_y = 0;
                        r.cleared = 1'b1;
                    end
                    else
                    begin
                        line_break();
                    end
                end
                sum = 0;
                for (int i = 0; i < code; i++)
                    if (loaded[i]) sum += glyph_w[i];
                if (sum > int'(gtcl_pkg::ATLAS_MAX)) sum = int'(gtcl_pkg::ATLAS_MAX);
                r.draw      = 1'b1;
                r.dest_x    = 12'(cur_x);
                r.dest_y    = 12'(cur_y);
                r.atlas_x   = 15'(sum);
                r.width_out = 8'(w);
                cur_x = clamp_cursor(cur_x + glyph_adv[code] + gap_x);
            end
            owed_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(layout_result_t got);
            layout_result_t want;
            if (owed_q.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t ns: unexpected result transfer, expected none, actual %p",
                             $time, got);
                return;
            end
            want = owed_q.pop_front();
            compare_field("draw",      32'(want.draw),      32'(got.draw));
            compare_field("cleared",   32'(want.cleared),   32'(got.cleared));
            compare_field("dest_x",    32'(want.dest_x),    32'(got.dest_x));
            compare_field("dest_y",    32'(want.dest_y),    32'(got.dest_y));
            compare_field("atlas_x",   32'(want.atlas_x),   32'(got.atlas_x));
            compare_field("width_out", 32'(want.width_out), 32'(got.width_out));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [gtcl_pkg::APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    int send_idle;
    int recv_idle;
    int cycles;

    layout_scoreboard sb = new();

    gtcl_in_if  in_ch();
    gtcl_out_if out_ch();

    glyph_text_cursor_layout u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("glyph_text_cursor_layout test failed");
            $finish;
        end
    end

    // Both channels are observed here, so prediction follows accepted transfers only.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_item('{in_ch.action, in_ch.char_code, in_ch.load_width,
                               in_ch.load_advance});
            if (out_ch.valid && out_ch.ready)
                sb.check_result('{out_ch.draw, out_ch.cleared, out_ch.dest_x, out_ch.dest_y,
                                  out_ch.atlas_x, out_ch.width_out});
        end
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_reg(input logic [2:0] idx);
        logic [31:0] rd;
        apb_access(1'b0, idx, 32'd0, rd);
        if (rd !== sb.reg_value(idx))
        begin
            sb.errors++;
            $display("%0t ns: register %0d readback mismatch, expected %0d, actual %0d",
                     $time, idx, sb.reg_value(idx), rd);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] unused;
        apb_access(1'b1, idx, val, unused);
        sb.set_reg(idx, val);
        check_reg(idx);
    endtask

    task automatic set_layout(input int tw, input int th, input int gh, input int sx,
                              input int sy);
        write_reg(gtcl_pkg::REG_TARGET_WIDTH, 32'(tw));
        write_reg(gtcl_pkg::REG_TARGET_HEIGHT, 32'(th));
        write_reg(gtcl_pkg::REG_GLYPH_HEIGHT, 32'(gh));
        write_reg(gtcl_pkg::REG_SPACING_X, 32'(sx));
        write_reg(gtcl_pkg::REG_SPACING_Y, 32'(sy));
    endtask

    task automatic push_item(input logic act, input logic [6:0] code, input logic [7:0] w,
                             input logic [7:0] adv);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.action       = act;
        in_ch.char_code    = code;
        in_ch.load_width   = w;
        in_ch.load_advance = adv;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // The sender holds off until the block has returned every owed result.
    task automatic drain_results();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_size();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return 8'd0;
        if (sel == 1) return 8'($urandom);
        return 8'($urandom_range(48, 1));
    endfunction

    task automatic push_random();
        logic       act;
        logic [6:0] code;
        int         pick;
        act  = ($urandom_range(99) < 15) ? gtcl_pkg::ACT_LOAD : gtcl_pkg::ACT_PLACE;
        pick = $urandom_range(99);
        if (act == gtcl_pkg::ACT_LOAD || pick >= 22) code = 7'($urandom_range(127));
        else if (pick < 4) code = gtcl_pkg::CHAR_CLEAR;
        else if (pick < 14) code = gtcl_pkg::CHAR_SPACE;
        else code = gtcl_pkg::CHAR_NEWLINE;
        if (act == gtcl_pkg::ACT_LOAD)
            push_item(act, code, pick_size(), pick_size());
        else
            push_item(act, code, 8'($urandom), 8'($urandom));
    endtask

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_ch.valid        = 1'b0;
        in_ch.action       = gtcl_pkg::ACT_LOAD;
        in_ch.char_code    = '0;
        in_ch.load_width   = '0;
        in_ch.load_advance = '0;
        send_idle          = 18;
        recv_idle          = 61;
        cycles             = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < 5; r++)
            check_reg(3'(r));

        // Directed part runs on the reset layout.
        push_item(gtcl_pkg::ACT_PLACE, 7'd65, 8'd0, 8'd0);
        push_item(gtcl_pkg::ACT_LOAD, gtcl_pkg::CHAR_CLEAR, 8'd255, 8'd255);
        push_item(gtcl_pkg::ACT_LOAD, gtcl_pkg::CHAR_NEWLINE, 8'd3, 8'd3);
        push_item(gtcl_pkg::ACT_LOAD, gtcl_pkg::CHAR_SPACE, 8'd5, 8'd5);
        push_item(gtcl_pkg::ACT_LOAD, 7'd65, 8'd8, 8'd10);
        push_item(gtcl_pkg::ACT_LOAD, 7'd65, 8'd99, 8'd99);
        push_item(gtcl_pkg::ACT_LOAD, 7'd66, 8'd0, 8'd7);
        push_item(gtcl_pkg::ACT_LOAD, 7'd127, 8'd255, 8'd255);
        push_item(gtcl_pkg::ACT_LOAD, 7'd1, 8'd255, 8'd0);
        push_item(gtcl_pkg::ACT_PLACE, 7'd66, 8'd255, 8'd255);
        push_item(gtcl_pkg::ACT_PLACE, 7'd65, 8'd0, 8'd0);
        push_item(gtcl_pkg::ACT_PLACE, 7'd1, 8'd0, 8'd0);
        push_item(gtcl_pkg::ACT_PLACE, 7'd127, 8'd0, 8'd0);
        push_item(gtcl_pkg::ACT_PLACE, 7'd127, 8'd0, 8'd0);
        push_item(gtcl_pkg::ACT_PLACE, 7'd127, 8'd0, 8'd0);
        push_item(gtcl_pkg::ACT_PLACE, gtcl_pkg::CHAR_SPACE, 8'd0, 8'd0);
        push_item(gtcl_pkg::ACT_PLACE, gtcl_pkg::CHAR_NEWLINE, 8'd0, 8'd0);
        push_item(gtcl_pkg::ACT_PLACE, gtcl_pkg::CHAR_CLEAR, 8'd0, 8'd0);
        push_item(gtcl_pkg::ACT_PLACE, 7'd1, 8'd0, 8'd0);
        drain_results();

        for (int phase = 0; phase < 6; phase++)
        begin
            send_idle = (phase < 2) ? 18 : (phase < 4) ? 61 : 0;
            recv_idle = (phase < 2) ? 61 : (phase < 4) ? 18 : 0;
            case (phase)
                0: set_layout(200, 100, 16, 3, 2);
                1: set_layout(4095, 4095, 255, 255, 255);
                2: set_layout(1, 1, 1, 0, 0);
                3: set_layout(0, 0, 0, $urandom_range(255), $urandom_range(255));
                4: set_layout($urandom_range(1023, 1), $urandom_range(1023, 1),
                              $urandom_range(255, 1), $urandom_range(255),
                              $urandom_range(255));
                default: set_layout(int'(gtcl_pkg::TARGET_WIDTH_RST),
                                    int'(gtcl_pkg::TARGET_HEIGHT_RST),
                                    int'(gtcl_pkg::GLYPH_HEIGHT_RST),
                                    int'(gtcl_pkg::SPACING_X_RST),
                                    int'(gtcl_pkg::SPACING_Y_RST));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_random();
            drain_results();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("glyph_text_cursor_layout test passed");
        else
            $display("glyph_text_cursor_layout test failed");
        $finish;
    end

endmodule
